[design/mmof_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmof_pkg: shared definitions for the moving median outlier flag unit
// Sizes, register codes, reset values and the cell control bundle.
// ----------------------------------------------------------------------------
package mmof_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 12;
    localparam int WLEN_W      = 7;
    localparam int THRESH_W    = 16;
    localparam int POS_W       = $clog2(MAX_WINDOW);
    localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
    localparam int MED_W       = SAMPLE_BITS + 1;
    localparam int PROD_W      = MED_W + THRESH_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = (WLEN_W > THRESH_W) ? WLEN_W : THRESH_W;
    localparam int CMP_W       = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [LEN_W-1:0]       t_len;
    typedef logic [POS_W-1:0]       t_pos;
    typedef logic [MED_W-1:0]       t_med;
    typedef logic [WLEN_W-1:0]      t_wlen;
    typedef logic [THRESH_W-1:0]    t_thresh;
    typedef logic [PROD_W-1:0]      t_prod;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN = 1'b0,
        CFG_THRESHOLD  = 1'b1
    } t_cfg_idx;

    localparam t_wlen   WLEN_RESET   = t_wlen'(5);
    localparam t_thresh THRESH_RESET = t_thresh'(1024);

    // control broadcast to every cell of the sorted chain
    typedef struct packed {
        logic    upd;     // request accepted: cells load their next value
        logic    full;    // window full: the oldest sample leaves
        t_sample sample;  // entering sample
        t_sample oldest;  // leaving sample
    } t_cell_ctl;

    // window length as used: 0 acts as 1, above the chain size clamps
    function automatic t_len eff_len(t_wlen wl);
        logic [CMP_W-1:0] w;
        w = CMP_W'(wl);
        if (w == '0) begin
            return t_len'(1);
        end else if (w > CMP_W'(MAX_WINDOW)) begin
            return t_len'(MAX_WINDOW);
        end else begin
            return t_len'(w);
        end
    endfunction

endpackage

[design/mmof_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmof_if: request channels of the moving median outlier flag unit
// Sample channel in, result channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface mmof_in_if;
    logic              valid;
    logic              ready;
    mmof_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mmof_out_if;
    logic           valid;
    logic           ready;
    logic           checked;
    logic           outlier;
    mmof_pkg::t_med median_twice;

    modport source (output valid, output checked, output outlier, output median_twice,
                    input ready);
    modport sink   (input valid, input checked, input outlier, input median_twice,
                    output ready);
endinterface

[design/mmof_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmof_cell: one slot of the sorted window chain
// Holds one sample; on update keeps it, takes a neighbor's, or takes the new one.
// ----------------------------------------------------------------------------
module mmof_cell (
    input  logic                i_clk,
    input  mmof_pkg::t_cell_ctl i_ctl,
    input  logic                i_valid,
    input  logic                i_prev_g,
    input  logic                i_prev_e,
    input  logic                i_next_g,
    input  mmof_pkg::t_sample   i_prev_v,
    input  mmof_pkg::t_sample   i_next_v,
    output logic                o_g,
    output logic                o_e,
    output mmof_pkg::t_sample   o_v
);

    mmof_pkg::t_sample r_v;
    mmof_pkg::t_sample n_v;

    // g: slot sits above the new sample; e: slot at or above the leaving one
    assign o_g = !i_valid || (r_v > i_ctl.sample);
    assign o_e = i_ctl.full && (!i_valid || (r_v >= i_ctl.oldest));
    assign o_v = r_v;

    always_comb begin
        case ({o_e, o_g})
            2'b10: begin
                // between removal and insertion point: close gap from above
                n_v = i_next_g ? i_ctl.sample : i_next_v;
            end
            2'b01: begin
                // between insertion point and removal: open gap upward
                n_v = i_prev_g ? i_prev_v : i_ctl.sample;
            end
            2'b11: begin
                if (!i_prev_g && !i_prev_e) begin
                    n_v = i_ctl.sample;
                end else if (i_prev_g && !i_prev_e) begin
                    n_v = i_prev_v;
                end else begin
                    n_v = r_v;
                end
            end
            default: begin
                n_v = r_v;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            r_v <= n_v;
        end
    end

endmodule

[design/mmof_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmof_chain: row of sorted window cells
// Cells below the fill count are live; neighbors exchange compare flags.
// ----------------------------------------------------------------------------
module mmof_chain (
    input  logic                i_clk,
    input  mmof_pkg::t_cell_ctl i_ctl,
    input  mmof_pkg::t_len      i_fill,
    output mmof_pkg::t_sample   o_vals [mmof_pkg::MAX_WINDOW]
);

    logic              w_g [mmof_pkg::MAX_WINDOW];
    logic              w_e [mmof_pkg::MAX_WINDOW];
    mmof_pkg::t_sample w_v [mmof_pkg::MAX_WINDOW];

    genvar gi;
    generate
        for (gi = 0; gi < mmof_pkg::MAX_WINDOW; gi++) begin : g_cell
            logic              w_valid;
            logic              w_prev_g;
            logic              w_prev_e;
            logic              w_next_g;
            mmof_pkg::t_sample w_prev_v;
            mmof_pkg::t_sample w_next_v;

            assign w_valid = mmof_pkg::t_len'(gi) < i_fill;

            if (gi == 0) begin : g_first
                assign w_prev_g = 1'b0;
                assign w_prev_e = 1'b0;
                assign w_prev_v = '0;
            end else begin : g_mid
                assign w_prev_g = w_g[gi-1];
                assign w_prev_e = w_e[gi-1];
                assign w_prev_v = w_v[gi-1];
            end

            if (gi == mmof_pkg::MAX_WINDOW - 1) begin : g_last
                assign w_next_g = 1'b1;
                assign w_next_v = '0;
            end else begin : g_up
                assign w_next_g = w_g[gi+1];
                assign w_next_v = w_v[gi+1];
            end

            mmof_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (i_ctl),
                .i_valid  (w_valid),
                .i_prev_g (w_prev_g),
                .i_prev_e (w_prev_e),
                .i_next_g (w_next_g),
                .i_prev_v (w_prev_v),
                .i_next_v (w_next_v),
                .o_g      (w_g[gi]),
                .o_e      (w_e[gi]),
                .o_v      (w_v[gi])
            );

            assign o_vals[gi] = w_v[gi];
        end
    endgenerate

endmodule

[design/mmof_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmof_ring: arrival order store
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module mmof_ring (
    input  logic              i_clk,
    input  logic              i_we,
    input  mmof_pkg::t_pos    i_waddr,
    input  mmof_pkg::t_sample i_wdata,
    input  mmof_pkg::t_pos    i_raddr,
    output mmof_pkg::t_sample o_rdata
);

    mmof_pkg::t_sample r_mem [mmof_pkg::MAX_WINDOW];
    mmof_pkg::t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/moving_median_outlier_flag_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_median_outlier_flag_unit: sliding window median with outlier flag
// Sorted cell chain, arrival ring and median/deviation stage.
// ----------------------------------------------------------------------------
// Each accepted sample is checked against twice the median of the previous
// full window (outlier when 4096*|2*sample - median_twice| > threshold *
// median_twice, threshold in unsigned Q4.12), then enters the window while the
// oldest sample leaves; the result carries twice the new median, or twice the
// last full window's median while the window still fills. On accept the sorted
// chain updates in place and the arrival ring is written; the second step
// picks the middle cells, forms the new median and the flag, and reads the
// next leaving sample from the ring. A result that waits at the output
// holds that second step and so the next request. Writing window_len empties
// the window; checking restarts once a full window has been seen again.
// Writing threshold keeps the window. Configure only while idle.
// ----------------------------------------------------------------------------
module moving_median_outlier_flag_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    mmof_in_if.sink                              i_in,
    mmof_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [mmof_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mmof_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // configuration
    mmof_pkg::t_wlen   r_wlen;
    mmof_pkg::t_thresh r_thresh;

    // window bookkeeping
    mmof_pkg::t_len    r_fill;
    mmof_pkg::t_pos    r_ring_pos;
    mmof_pkg::t_med    r_last_med;
    logic              r_med_ready;

    // second step: deviation and product captured at accept
    logic              r_busy;
    logic              r_chk;
    mmof_pkg::t_med    r_dev;
    mmof_pkg::t_prod   r_prod;

    // output register
    logic              r_out_valid;
    logic              r_out_chk;
    logic              r_out_outl;
    mmof_pkg::t_med    r_out_med;

    mmof_pkg::t_len      w_len;
    logic                w_accept;
    logic                w_fire;
    logic                w_full;
    mmof_pkg::t_sample   w_oldest;
    mmof_pkg::t_pos      w_wpos;
    mmof_pkg::t_len      w_pos_inc;
    mmof_pkg::t_med      w_s2;
    mmof_pkg::t_med      w_dev;
    mmof_pkg::t_cell_ctl w_ctl;
    mmof_pkg::t_sample   w_vals [mmof_pkg::MAX_WINDOW];
    mmof_pkg::t_pos      w_lo;
    mmof_pkg::t_pos      w_hi;
    mmof_pkg::t_med      w_med;
    logic                w_outl;
    mmof_pkg::t_len      w_len_m1;
    mmof_pkg::t_len      w_len_half;

    assign w_len    = mmof_pkg::eff_len(r_wlen);
    assign w_accept = i_in.valid && i_in.ready;
    assign w_fire   = r_busy && (!r_out_valid || o_out.ready);
    assign w_full   = r_fill >= w_len;

    assign i_in.ready = !r_busy;

    // deviation against the previous median, both doubled
    assign w_s2  = {i_in.sample, 1'b0};
    assign w_dev = (r_last_med > w_s2) ? (r_last_med - w_s2) : (w_s2 - r_last_med);

    // ring slot for the entering sample; wraps at the window length
    assign w_wpos    = (mmof_pkg::t_len'(r_ring_pos) >= w_len) ? '0 : r_ring_pos;
    assign w_pos_inc = mmof_pkg::t_len'(w_wpos) + mmof_pkg::t_len'(1);

    assign w_ctl.upd    = w_accept;
    assign w_ctl.full   = w_full;
    assign w_ctl.sample = i_in.sample;
    assign w_ctl.oldest = w_oldest;

    mmof_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_fill (r_fill),
        .o_vals (w_vals)
    );

    // read port follows the ring pointer through the ring's read register
    mmof_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_wpos),
        .i_wdata (i_in.sample),
        .i_raddr (r_ring_pos),
        .o_rdata (w_oldest)
    );

    // middle cells: odd length uses one cell twice
    assign w_len_m1   = w_len - mmof_pkg::t_len'(1);
    assign w_len_half = w_len >> 1;
    assign w_lo  = mmof_pkg::t_pos'(w_len_m1 >> 1);
    assign w_hi  = w_len[0] ? w_lo : mmof_pkg::t_pos'(w_len_half);
    assign w_med = mmof_pkg::t_med'(w_vals[w_lo]) + mmof_pkg::t_med'(w_vals[w_hi]);

    assign w_outl = r_chk &&
        (mmof_pkg::t_prod'({r_dev, {mmof_pkg::FRAC_BITS{1'b0}}}) > r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen      <= mmof_pkg::WLEN_RESET;
            r_thresh    <= mmof_pkg::THRESH_RESET;
            r_fill      <= '0;
            r_ring_pos  <= '0;
            r_last_med  <= '0;
            r_med_ready <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_accept) begin
                r_busy     <= 1'b1;
                r_chk      <= r_med_ready;
                r_dev      <= w_dev;
                r_prod     <= mmof_pkg::t_prod'(r_thresh) * mmof_pkg::t_prod'(r_last_med);
                r_ring_pos <= (w_pos_inc == w_len) ? '0 : mmof_pkg::t_pos'(w_pos_inc);
                if (!w_full) begin
                    r_fill <= r_fill + mmof_pkg::t_len'(1);
                end
            end

            if (w_fire) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
                r_out_chk   <= r_chk;
                r_out_outl  <= w_outl;
                if (w_full) begin
                    r_last_med  <= w_med;
                    r_med_ready <= 1'b1;
                    r_out_med   <= w_med;
                end else begin
                    r_out_med   <= r_last_med;
                end
            end

            if (i_cfg_we) begin
                case (mmof_pkg::t_cfg_idx'(i_cfg_idx))
                    mmof_pkg::CFG_WINDOW_LEN: begin
                        r_wlen      <= mmof_pkg::t_wlen'(i_cfg_data);
                        r_fill      <= '0;
                        r_ring_pos  <= '0;
                        r_last_med  <= '0;
                        r_med_ready <= 1'b0;
                    end
                    mmof_pkg::CFG_THRESHOLD: begin
                        r_thresh <= mmof_pkg::t_thresh'(i_cfg_data);
                    end
                    default: begin
                        r_thresh <= r_thresh;
                    end
                endcase
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.checked      = r_out_chk;
    assign o_out.outlier      = r_out_outl;
    assign o_out.median_twice = r_out_med;

endmodule

[design/mmof_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmof_checker: port level checks for the moving median outlier flag unit
// Bound to the top level; watches the request channels only.
// ----------------------------------------------------------------------------
module mmof_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_checked,
    input logic i_out_outlier
);

    // a result offered and not taken stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // no flag without a check
    a_flag_needs_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_outlier |-> i_out_checked)
        else $error("outlier flagged on unchecked sample");

    // one sample in flight: intake closes right after a request
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second sample taken while first in flight");

    // a new result only comes out of a busy cycle
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a sample in flight");

endmodule

bind moving_median_outlier_flag_unit mmof_checker u_mmof_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_checked (o_out.checked),
    .i_out_outlier (o_out.outlier)
);

[bench/moving_median_outlier_flag_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_median_outlier_flag_unit_tb: self-checking bench for the median unit
// Drives samples through a valid/ready channel under random idling and a long
// result-side hold, predicts checked/outlier/median_twice per request from a
// sliding window kept here, and compares every result against the oldest
// prediction.
// ----------------------------------------------------------------------------
module moving_median_outlier_flag_unit_tb;
    import mmof_pkg::*;

    // longest legal quiet stretch is the receiver hold plus random stalls
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 125;

    typedef struct packed {
        logic checked;
        logic outlier;
        t_med median_twice;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mmof_in_if  in_ch ();
    mmof_out_if out_ch ();

    moving_median_outlier_flag_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Window predictor: arrival order plus a sorted copy of the same set
    // ------------------------------------------------------------------
    t_sample     arrival_q[$];
    t_sample     ordered_q[$];
    int unsigned win_size;
    t_thresh     thr_q12;
    t_med        prev_med2;
    logic        med_ready;

    t_sample     sample_queue[$];     // samples waiting to be offered
    t_result     pending_results[$];  // predictions not yet matched

    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        rx_hold;
    int          fail_cnt  = 0;
    int          stall_cnt = 0;

    // 0 acts as 1, anything past the chain clamps to the chain size
    function automatic int unsigned window_size_of(input t_wlen wl);
        if (wl == '0) begin
            return 1;
        end else if (int'(wl) > MAX_WINDOW) begin
            return MAX_WINDOW;
        end
        return int'(wl);
    endfunction

    // window_len write empties the window and restarts checking
    task automatic reset_window(input t_wlen wl);
        arrival_q.delete();
        ordered_q.delete();
        win_size  = window_size_of(wl);
        prev_med2 = '0;
        med_ready = 1'b0;
    endtask

    // append one sample to the offer queue
    task automatic queue_sample(input t_sample s);
        sample_queue.insert(sample_queue.size(), s);
    endtask

    task automatic median_filter_predict(input t_sample s);
        t_result     r;
        logic [63:0] m2;
        logic [63:0] s2;
        logic [63:0] dev;
        t_sample     leaving;
        int          i;
        r = '0;
        // check against the median of the previous full window
        if (med_ready) begin
            m2        = 64'(prev_med2);
            s2        = 64'(s) << 1;
            dev       = (m2 > s2) ? (m2 - s2) : (s2 - m2);
            r.checked = 1'b1;
            r.outlier = (dev << FRAC_BITS) > (64'(thr_q12) * m2);
        end
        // oldest leaves only once the window is full
        if (arrival_q.size() == int'(win_size)) begin
            leaving = arrival_q[0];
            arrival_q.delete(0);
            for (i = 0; i < ordered_q.size(); i++) begin
                if (ordered_q[i] == leaving) begin
                    ordered_q.delete(i);
                    break;
                end
            end
        end
        arrival_q.insert(arrival_q.size(), s);
        i = 0;
        while (i < ordered_q.size() && ordered_q[i] <= s) i++;
        ordered_q.insert(i, s);
        if (ordered_q.size() == int'(win_size)) begin
            if (win_size % 2 == 1) begin
                prev_med2 = {ordered_q[(win_size - 1) / 2], 1'b0};
            end else begin
                prev_med2 = t_med'(ordered_q[win_size / 2 - 1]) +
                            t_med'(ordered_q[win_size / 2]);
            end
            med_ready = 1'b1;
        end
        r.median_twice = prev_med2;
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic report_mismatch(input string what, input int unsigned exp_v,
                                   input int unsigned got_v);
        fail_cnt++;
        $display("%0t mismatch %s: expected %0d got %0d", $time, what, exp_v, got_v);
    endtask

    // ------------------------------------------------------------------
    // Request driver: offers queued samples, predicts on each accept
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) median_filter_predict(in_ch.sample);
            // a held request stays up until taken
            if (!in_ch.valid || in_ch.ready) begin
                if (sample_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    in_ch.valid  <= 1'b1;
                    in_ch.sample <= sample_queue[0];
                    sample_queue.delete(0);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: field-by-field compare with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, out_ch.median_twice);
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (out_ch.checked !== want.checked)
                        report_mismatch("checked", want.checked, out_ch.checked);
                    if (out_ch.outlier !== want.outlier)
                        report_mismatch("outlier", want.outlier, out_ch.outlier);
                    if (out_ch.median_twice !== want.median_twice)
                        report_mismatch("median_twice", want.median_twice,
                                        out_ch.median_twice);
                end
            end
            out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // hang detector: no request moved on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt == STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_WINDOW_LEN) reset_window(t_wlen'(val));
        else thr_q12 = t_thresh'(val);
    endtask

    // all offered, all answered, then the pipe gets to settle
    task automatic drain();
        do @(negedge i_clk);
        while (sample_queue.size() != 0 || in_ch.valid || pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly a noisy level so checks land near the threshold, plus extremes
    function automatic t_sample draw_sample(input t_sample level);
        int unsigned pick;
        int          spread;
        int          v;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (pick <= 3) return t_sample'($urandom);
        spread = int'(level) / 4 + 4;
        v = int'(level) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return t_sample'(v);
    endfunction

    // window extremes, out-of-range lengths and thresholds; -1 means random
    t_wlen phase_wlen[NUM_PHASES] = '{7'd5, 7'd1, 7'd2, 7'd64, 7'd127, 7'd3,
                                      7'd0, 7'd8, 7'd65, 7'd63, 7'd17, 7'd4};
    int    phase_thr[NUM_PHASES]  = '{1024, 4096, 0, 512, 65535, -1,
                                      2048, -1, 800, 1500, -1, -1};

    initial begin
        t_sample level;
        int      p;
        int      n;
        int      thr;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_WINDOW_LEN;
        i_cfg_data   = '0;
        rx_hold      = 1'b0;
        tx_idle_pct  = 20;
        rx_idle_pct  = 76;
        reset_window(WLEN_RESET);
        thr_q12      = THRESH_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero median, then a sample off a zero median
        repeat (6) queue_sample(16'h0000);
        queue_sample(16'h0001);
        repeat (3) queue_sample(16'hFFFF);
        queue_sample(16'h5555);
        queue_sample(16'hAAAA);
        drain();

        // threshold changes keep the window and its median
        write_reg(CFG_THRESHOLD, 16'h0000);
        queue_sample(16'hAAAA);
        queue_sample(16'hAAAB);
        queue_sample(16'h1234);
        drain();
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        queue_sample(16'h0001);
        queue_sample(16'hFFFF);
        queue_sample(16'h8000);
        drain();

        // zero length acts as a one-sample window
        write_reg(CFG_WINDOW_LEN, 16'd0);
        write_reg(CFG_THRESHOLD, 16'd4096);
        queue_sample(16'd100);
        queue_sample(16'd200);
        queue_sample(16'd100);
        queue_sample(16'd0);
        drain();

        // even window: median is the sum of the two middle values
        write_reg(CFG_WINDOW_LEN, 16'd2);
        queue_sample(16'd10);
        queue_sample(16'd20);
        queue_sample(16'd15);
        queue_sample(16'd40);
        drain();

        for (p = 0; p < NUM_PHASES; p++) begin
            // idling pattern: sender light/receiver heavy, swapped, then none
            if (p < 4) begin
                tx_idle_pct = 20;
                rx_idle_pct = 76;
            end else if (p < 8) begin
                tx_idle_pct = 76;
                rx_idle_pct = 20;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            thr = (phase_thr[p] < 0) ? int'($urandom_range(0, 65535)) : phase_thr[p];
            write_reg(CFG_WINDOW_LEN, CFG_DATA_W'(phase_wlen[p]));
            write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));

            level = t_sample'($urandom);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // level hops now and then; sometimes near zero
                if ($urandom_range(0, 29) == 0)
                    level = ($urandom_range(0, 3) == 0) ? t_sample'($urandom_range(0, 8))
                                                        : t_sample'($urandom);
                queue_sample(draw_sample(level));
            end

            // last phase: hold the result side so the unit backs up its input
            if (p == NUM_PHASES - 1) begin
                @(posedge i_clk);
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());

        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
